[rtl/ccf_pkg.sv]
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared types and constants of the conformal circle track fit unit.
// ----------------------------------------------------------------------------
package ccf_pkg;

	localparam int FRAC     = 30;
	localparam int HIT_MAX  = 4096;
	localparam int CNT_W    = 13;
	localparam int SUM_W    = 48;
	localparam int FIT_W    = 96;
	localparam int ALU_W    = 128;
	localparam int VAL_W    = 64;

	localparam logic [VAL_W-1:0] VAL_CAP = {2'b00, {(VAL_W-2){1'b1}}};

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_CUT   = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;

	localparam logic [1:0] CFG_MIN_HITS      = 2'd0;
	localparam logic [1:0] CFG_MIN_MAX_LAYER = 2'd1;
	localparam logic [1:0] CFG_PT_SCALE      = 2'd2;

	localparam logic [CNT_W-1:0] RST_MIN_HITS      = 13'd30;
	localparam logic [4:0]       RST_MIN_MAX_LAYER = 5'd4;
	localparam logic [15:0]      RST_PT_SCALE      = 16'd12280;

	typedef logic signed [FRAC:0] conf_t;

	typedef struct packed {
		conf_t      u;
		conf_t      v;
		logic       cls;
		logic       skip;
		logic       last;
		logic [4:0] max_layer;
	} hit_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] min_hits;
		logic [4:0]       min_max_layer;
		logic [15:0]      pt_scale;
	} cfg_t;

	typedef enum logic [1:0] {
		ALU_MUL  = 2'd0,
		ALU_DIV  = 2'd1,
		ALU_SQRT = 2'd2
	} alu_op_t;

endpackage

[rtl/conformal_circle_track_fit_unit.sv]
// ----------------------------------------------------------------------------
// conformal_circle_track_fit_unit
// Conformal-mapping circle fit of one track from a stream of wire hits.
// ----------------------------------------------------------------------------
// usage
//  hits enter on start while busy is low: hit_x, hit_y, layer, max_layer,
//  last_hit are sampled at that edge. the front end forms r2 and the two
//  conformal divisions bit by bit in the 30-step u/v divider; busy stays
//  high until the hit is pushed, which waits while the queue is full, and
//  no new hit is taken before then. a two-item queue lets the next hits
//  be mapped while the back end is still summing or fitting.
//  the back end adds a hit in its prod and acc states; after the hit marked
//  last it runs the cut checks and, if they pass, the fit on one shared
//  serial multiply/divide/root unit, then raises done for one cycle with
//  radius, pt, even_hits, odd_hits and status; the event sums then clear.
//  cfg_we writes register cfg_idx (0 min_hits, 1 min_max_layer, 2 pt_scale)
//  at once; write only while no event is in flight.
//  reset clears the queue, the event sums and loads the register defaults.
//  results cannot be held off: done marks the only cycle they are valid.
// ----------------------------------------------------------------------------
module conformal_circle_track_fit_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_idx,
	input  logic [15:0]               cfg_data,
	input  logic signed [15:0]        hit_x,
	input  logic signed [15:0]        hit_y,
	input  logic [4:0]                layer,
	input  logic [4:0]                max_layer,
	input  logic                      last_hit,
	output logic                      done,
	output logic [15:0]               radius,
	output logic [15:0]               pt,
	output logic [ccf_pkg::CNT_W-1:0] even_hits,
	output logic [ccf_pkg::CNT_W-1:0] odd_hits,
	output logic [1:0]                status
);
	import ccf_pkg::*;

	cfg_t      cfg_q;
	logic      q_push, q_pop, q_full, q_empty;
	hit_item_t q_in, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_hits      <= RST_MIN_HITS;
			cfg_q.min_max_layer <= RST_MIN_MAX_LAYER;
			cfg_q.pt_scale      <= RST_PT_SCALE;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MIN_HITS:      cfg_q.min_hits      <= cfg_data[CNT_W-1:0];
				CFG_MIN_MAX_LAYER: cfg_q.min_max_layer <= cfg_data[4:0];
				CFG_PT_SCALE:      cfg_q.pt_scale      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ccf_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.hit_x     (hit_x),
		.hit_y     (hit_y),
		.layer     (layer),
		.max_layer (max_layer),
		.last_hit  (last_hit),
		.full      (q_full),
		.busy      (busy),
		.push      (q_push),
		.push_item (q_in)
	);

	ccf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	ccf_fit u_fit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (q_empty),
		.head      (q_head),
		.pop       (q_pop),
		.done      (done),
		.radius    (radius),
		.pt        (pt),
		.even_hits (even_hits),
		.odd_hits  (odd_hits),
		.status    (status)
	);

endmodule

[rtl/ccf_map.sv]
// ----------------------------------------------------------------------------
// ccf_map
// Front end: takes one hit, forms r2 and maps it to conformal u, v.
// ----------------------------------------------------------------------------
module ccf_map (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] hit_x,
	input  logic signed [15:0] hit_y,
	input  logic [4:0]         layer,
	input  logic [4:0]         max_layer,
	input  logic               last_hit,
	input  logic               full,
	output logic               busy,
	output logic               push,
	output ccf_pkg::hit_item_t push_item
);
	import ccf_pkg::*;

	localparam int CW = $clog2(FRAC);

	typedef enum logic [4:0] {
		M_IDLE = 5'b00001,
		M_R2   = 5'b00010,
		M_PREP = 5'b00100,
		M_DIV  = 5'b01000,
		M_PUSH = 5'b10000
	} map_state_t;

	map_state_t         st_q;
	logic signed [15:0] x_q, y_q;
	logic               cls_q, last_q;
	logic [4:0]         maxl_q;
	logic [31:0]        r2_q;
	logic [32:0]        remx_q, remy_q;
	logic [FRAC-1:0]    qx_q, qy_q;
	logic               satx_q, saty_q;
	logic [CW-1:0]      cnt_q;

	logic [15:0]     ax, ay;
	logic [32:0]     tx, ty;
	logic            gex, gey;
	logic [FRAC-1:0] mu, mv;

	assign ax  = x_q[15] ? 16'(-x_q) : 16'(x_q);
	assign ay  = y_q[15] ? 16'(-y_q) : 16'(y_q);
	assign tx  = {remx_q[31:0], 1'b0};
	assign ty  = {remy_q[31:0], 1'b0};
	assign gex = tx >= {1'b0, r2_q};
	assign gey = ty >= {1'b0, r2_q};

	assign mu = satx_q ? '1 : qx_q;
	assign mv = saty_q ? '1 : qy_q;

	always_comb begin
		push_item.u         = x_q[15] ? -conf_t'({1'b0, mu}) : conf_t'({1'b0, mu});
		push_item.v         = y_q[15] ? -conf_t'({1'b0, mv}) : conf_t'({1'b0, mv});
		push_item.cls       = cls_q;
		push_item.skip      = (r2_q == 32'd0);
		push_item.last      = last_q;
		push_item.max_layer = maxl_q;
	end

	assign busy = (st_q != M_IDLE);
	assign push = (st_q == M_PUSH) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
		end else begin
			case (st_q)
				M_IDLE: if (start) st_q <= M_R2;
				M_R2:   st_q <= M_PREP;
				M_PREP: st_q <= M_DIV;
				M_DIV:  if (cnt_q == '0) st_q <= M_PUSH;
				M_PUSH: if (!full) st_q <= M_IDLE;
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: begin
				x_q    <= hit_x;
				y_q    <= hit_y;
				cls_q  <= layer[0];
				last_q <= last_hit;
				maxl_q <= max_layer;
			end
			M_R2: begin
				r2_q <= 32'(ax * ax) + 32'(ay * ay);
			end
			M_PREP: begin
				remx_q <= {11'd0, ax, 6'd0};
				remy_q <= {11'd0, ay, 6'd0};
				satx_q <= ({10'd0, ax, 6'd0} >= r2_q);
				saty_q <= ({10'd0, ay, 6'd0} >= r2_q);
				qx_q   <= '0;
				qy_q   <= '0;
				cnt_q  <= CW'(FRAC - 1);
			end
			M_DIV: begin
				remx_q <= gex ? tx - {1'b0, r2_q} : tx;
				remy_q <= gey ? ty - {1'b0, r2_q} : ty;
				qx_q   <= {qx_q[FRAC-2:0], gex};
				qy_q   <= {qy_q[FRAC-2:0], gey};
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/ccf_fifo.sv]
// ----------------------------------------------------------------------------
// ccf_fifo
// Two-entry item queue between the mapping front end and the fit back end.
// ----------------------------------------------------------------------------
module ccf_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ccf_pkg::hit_item_t push_item,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output ccf_pkg::hit_item_t head
);
	import ccf_pkg::*;

	hit_item_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

endmodule

[rtl/ccf_alu.sv]
// ----------------------------------------------------------------------------
// ccf_alu
// Shared bit-serial unit: multiply, divide and integer square root.
// ----------------------------------------------------------------------------
module ccf_alu (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  ccf_pkg::alu_op_t             op,
	input  logic [ccf_pkg::ALU_W-1:0]    opa,
	input  logic [ccf_pkg::ALU_W-1:0]    opb,
	output logic                         done,
	output logic [ccf_pkg::ALU_W-1:0]    res
);
	import ccf_pkg::*;

	alu_op_t          op_q;
	logic             busy_q, done_q;
	logic [6:0]       cnt_q;
	logic [ALU_W-1:0] x_q, y_q, quo_q;
	logic [ALU_W:0]   acc_q;

	logic [ALU_W:0]   rem, trial, acc_n;
	logic             ge;
	logic [ALU_W-1:0] x_n;

	always_comb begin
		rem   = '0;
		trial = '0;
		ge    = 1'b0;
		acc_n = acc_q;
		x_n   = x_q;
		case (op_q)
			ALU_MUL: begin
				acc_n = {acc_q[ALU_W-1:0], 1'b0} + (x_q[ALU_W-1] ? {1'b0, y_q} : '0);
				x_n   = {x_q[ALU_W-2:0], 1'b0};
			end
			ALU_DIV: begin
				rem   = {acc_q[ALU_W-1:0], x_q[ALU_W-1]};
				ge    = rem >= {1'b0, y_q};
				acc_n = ge ? rem - {1'b0, y_q} : rem;
				x_n   = {x_q[ALU_W-2:0], 1'b0};
			end
			ALU_SQRT: begin
				rem   = {acc_q[ALU_W-2:0], x_q[ALU_W-1:ALU_W-2]};
				trial = {quo_q[ALU_W-2:0], 2'b01};
				ge    = rem >= trial;
				acc_n = ge ? rem - trial : rem;
				x_n   = {x_q[ALU_W-3:0], 2'b00};
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign res  = (op_q == ALU_MUL) ? acc_q[ALU_W-1:0] : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (go) begin
				busy_q <= 1'b1;
				op_q   <= op;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			quo_q <= '0;
			case (op)
				ALU_MUL: begin
					x_q   <= {opb[63:0], 64'd0};
					y_q   <= opa;
					cnt_q <= 7'd63;
				end
				ALU_DIV: begin
					x_q   <= opa;
					y_q   <= opb;
					cnt_q <= 7'd127;
				end
				default: begin
					x_q   <= opa;
					y_q   <= opb;
					cnt_q <= 7'd63;
				end
			endcase
		end else if (busy_q) begin
			acc_q <= acc_n;
			x_q   <= x_n;
			quo_q <= {quo_q[ALU_W-2:0], ge};
			cnt_q <= cnt_q - 7'd1;
		end
	end

endmodule

[rtl/ccf_fit.sv]
// ----------------------------------------------------------------------------
// ccf_fit
// Back end: accumulates per-parity sums and runs the event fit sequence.
// ----------------------------------------------------------------------------
module ccf_fit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ccf_pkg::cfg_t               cfg,
	input  logic                        empty,
	input  ccf_pkg::hit_item_t          head,
	output logic                        pop,
	output logic                        done,
	output logic [15:0]                 radius,
	output logic [15:0]                 pt,
	output logic [ccf_pkg::CNT_W-1:0]   even_hits,
	output logic [ccf_pkg::CNT_W-1:0]   odd_hits,
	output logic [1:0]                  status
);
	import ccf_pkg::*;

	typedef enum logic [17:0] {
		B_IDLE = 18'h00001,
		B_PROD = 18'h00002,
		B_ACC  = 18'h00004,
		B_CUT  = 18'h00008,
		B_M1   = 18'h00010,
		B_M2   = 18'h00020,
		B_M3   = 18'h00040,
		B_M4   = 18'h00080,
		B_M5   = 18'h00100,
		B_M6   = 18'h00200,
		B_D1   = 18'h00400,
		B_D2   = 18'h00800,
		B_AVG  = 18'h01000,
		B_SQ   = 18'h02000,
		B_SQRT = 18'h04000,
		B_RDIV = 18'h08000,
		B_PT   = 18'h10000,
		B_OUT  = 18'h20000
	} fit_state_t;

	fit_state_t st_q;
	logic       issued_q, cls_q;

	hit_item_t          h_q;
	logic [FRAC-1:0]    puu_q;
	conf_t              puv_q;

	logic [CNT_W-1:0]        cnt_q [2];
	logic [CNT_W-1:0]        tot_q;
	logic signed [SUM_W-1:0] su_q [2], sv_q [2], suu_q [2], suv_q [2];

	logic signed [FIT_W-1:0] t_q, nb_q, na_q;
	logic [FIT_W-1:0]        d_q;
	logic signed [VAL_W-1:0] slope_q [2], off_q [2];
	logic signed [VAL_W-1:0] bavg_q, aavg_q;
	logic [32:0]             rw_q;
	logic [15:0]             rad_q, pt_q;
	logic [1:0]              stat_q;

	logic             alu_go, alu_done, arith, sgn;
	alu_op_t          alu_op;
	logic [ALU_W-1:0] opa, opb, alu_res;

	logic [FRAC-1:0]         au, av;
	logic [2*FRAC-1:0]       uu_full, uv_full;
	logic [CNT_W-1:0]        n_c;
	logic signed [SUM_W-1:0] su_c, sv_c, suu_c, suv_c;
	logic signed [FIT_W-1:0] sres, sres_sh, dn, diff;
	logic [FIT_W-1:0]        pm, nbmag, namag;
	logic signed [VAL_W:0]   sum_b, sum_a, sa_b, sa_a;
	logic signed [VAL_W-1:0] avg_b, avg_a, qval;
	logic [48:0]             ptp;

	function automatic logic [SUM_W-1:0] mag_s(input logic signed [SUM_W-1:0] a);
		mag_s = a[SUM_W-1] ? SUM_W'(-a) : SUM_W'(a);
	endfunction

	function automatic logic [VAL_W-1:0] mag_v(input logic signed [VAL_W-1:0] a);
		mag_v = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
	endfunction

	function automatic logic signed [VAL_W-1:0] cap_sign(input logic [ALU_W-1:0] q,
		input logic neg);
		logic [VAL_W-1:0] m;
		m = (q > ALU_W'(VAL_CAP)) ? VAL_CAP : q[VAL_W-1:0];
		cap_sign = neg ? -$signed(m) : $signed(m);
	endfunction

	// per-hit products, magnitudes are below 2^FRAC
	assign au      = h_q.u[FRAC] ? FRAC'(-h_q.u) : FRAC'(h_q.u);
	assign av      = h_q.v[FRAC] ? FRAC'(-h_q.v) : FRAC'(h_q.v);
	assign uu_full = au * au;
	assign uv_full = au * av;

	assign n_c   = cnt_q[cls_q];
	assign su_c  = su_q[cls_q];
	assign sv_c  = sv_q[cls_q];
	assign suu_c = suu_q[cls_q];
	assign suv_c = suv_q[cls_q];

	assign arith = (st_q == B_M1) || (st_q == B_M2) || (st_q == B_M3) || (st_q == B_M4) ||
		(st_q == B_M5) || (st_q == B_M6) || (st_q == B_D1) || (st_q == B_D2) ||
		(st_q == B_SQ) || (st_q == B_SQRT) || (st_q == B_RDIV);
	assign alu_go = arith && !issued_q;

	assign nbmag = nb_q[FIT_W-1] ? FIT_W'(-nb_q) : FIT_W'(nb_q);
	assign namag = na_q[FIT_W-1] ? FIT_W'(-na_q) : FIT_W'(na_q);

	always_comb begin
		alu_op = ALU_MUL;
		opa    = '0;
		opb    = '0;
		sgn    = 1'b0;
		case (st_q)
			B_M1: begin
				opa = ALU_W'(n_c);
				opb = ALU_W'(mag_s(suu_c));
			end
			B_M2: begin
				opa = ALU_W'(mag_s(su_c));
				opb = ALU_W'(mag_s(su_c));
			end
			B_M3: begin
				opa = ALU_W'(n_c);
				opb = ALU_W'(mag_s(suv_c));
				sgn = suv_c[SUM_W-1];
			end
			B_M4: begin
				opa = ALU_W'(mag_s(su_c));
				opb = ALU_W'(mag_s(sv_c));
				sgn = su_c[SUM_W-1] ^ sv_c[SUM_W-1];
			end
			B_M5: begin
				opa = ALU_W'(mag_s(suu_c));
				opb = ALU_W'(mag_s(sv_c));
				sgn = suu_c[SUM_W-1] ^ sv_c[SUM_W-1];
			end
			B_M6: begin
				opa = ALU_W'(mag_s(su_c));
				opb = ALU_W'(mag_s(suv_c));
				sgn = su_c[SUM_W-1] ^ suv_c[SUM_W-1];
			end
			B_D1: begin
				alu_op = ALU_DIV;
				opa    = ALU_W'({nbmag, {FRAC{1'b0}}});
				opb    = ALU_W'(d_q);
			end
			B_D2: begin
				alu_op = ALU_DIV;
				opa    = ALU_W'({namag, {FRAC{1'b0}}});
				opb    = ALU_W'(d_q);
			end
			B_SQ: begin
				opa = ALU_W'(mag_v(bavg_q));
				opb = ALU_W'(mag_v(bavg_q));
			end
			B_SQRT: begin
				alu_op = ALU_SQRT;
				opa    = alu_res + (ALU_W'(1) << (2 * FRAC));
			end
			B_RDIV: begin
				alu_op = ALU_DIV;
				opa    = {alu_res[ALU_W-6:0], 5'd0};
				opb    = ALU_W'(mag_v(aavg_q));
			end
			default: begin
			end
		endcase
	end

	assign pm      = alu_res[FIT_W-1:0];
	assign sres    = sgn ? -$signed(pm) : $signed(pm);
	assign sres_sh = sres <<< FRAC;
	assign dn      = t_q - sres;
	assign diff    = t_q - sres;
	assign qval    = cap_sign(alu_res, (st_q == B_D1) ? nb_q[FIT_W-1] : na_q[FIT_W-1]);

	assign sum_b = {slope_q[0][VAL_W-1], slope_q[0]} + {slope_q[1][VAL_W-1], slope_q[1]};
	assign sum_a = {off_q[0][VAL_W-1], off_q[0]} + {off_q[1][VAL_W-1], off_q[1]};
	assign sa_b  = sum_b + (VAL_W+1)'(sum_b[VAL_W]);
	assign sa_a  = sum_a + (VAL_W+1)'(sum_a[VAL_W]);
	assign avg_b = sa_b[VAL_W:1];
	assign avg_a = sa_a[VAL_W:1];

	assign ptp = rw_q * cfg.pt_scale;

	assign pop       = (st_q == B_IDLE) && !empty;
	assign done      = (st_q == B_OUT);
	assign radius    = rad_q;
	assign pt        = pt_q;
	assign status    = stat_q;
	assign even_hits = cnt_q[0];
	assign odd_hits  = cnt_q[1];

	ccf_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (alu_go),
		.op     (alu_op),
		.opa    (opa),
		.opb    (opb),
		.done   (alu_done),
		.res    (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			issued_q <= 1'b0;
			cls_q    <= 1'b0;
			tot_q    <= '0;
			for (int c = 0; c < 2; c++) begin
				cnt_q[c] <= '0;
				su_q[c]  <= '0;
				sv_q[c]  <= '0;
				suu_q[c] <= '0;
				suv_q[c] <= '0;
			end
		end else begin
			if (alu_go) issued_q <= 1'b1;
			else if (alu_done) issued_q <= 1'b0;
			case (st_q)
				B_IDLE: if (!empty) st_q <= B_PROD;
				B_PROD: st_q <= B_ACC;
				B_ACC: begin
					if (!h_q.skip && tot_q < CNT_W'(HIT_MAX)) begin
						su_q[h_q.cls]  <= su_q[h_q.cls] + SUM_W'(h_q.u);
						sv_q[h_q.cls]  <= sv_q[h_q.cls] + SUM_W'(h_q.v);
						suu_q[h_q.cls] <= suu_q[h_q.cls] + SUM_W'(puu_q);
						suv_q[h_q.cls] <= suv_q[h_q.cls] + SUM_W'(puv_q);
						cnt_q[h_q.cls] <= cnt_q[h_q.cls] + 1'b1;
						tot_q          <= tot_q + 1'b1;
					end
					st_q <= h_q.last ? B_CUT : B_IDLE;
				end
				B_CUT: begin
					cls_q <= 1'b0;
					if (tot_q < cfg.min_hits || h_q.max_layer < cfg.min_max_layer) begin
						st_q <= B_OUT;
					end else if (cnt_q[0] < CNT_W'(2) || cnt_q[1] < CNT_W'(2)) begin
						st_q <= B_OUT;
					end else begin
						st_q <= B_M1;
					end
				end
				B_M1: if (alu_done) st_q <= B_M2;
				B_M2: if (alu_done) st_q <= (dn[FIT_W-1] || dn == '0) ? B_OUT : B_M3;
				B_M3: if (alu_done) st_q <= B_M4;
				B_M4: if (alu_done) st_q <= B_M5;
				B_M5: if (alu_done) st_q <= B_M6;
				B_M6: if (alu_done) st_q <= B_D1;
				B_D1: if (alu_done) st_q <= B_D2;
				B_D2: begin
					if (alu_done) begin
						cls_q <= 1'b1;
						st_q  <= cls_q ? B_AVG : B_M1;
					end
				end
				B_AVG:  st_q <= (avg_a == '0) ? B_OUT : B_SQ;
				B_SQ:   if (alu_done) st_q <= B_SQRT;
				B_SQRT: if (alu_done) st_q <= B_RDIV;
				B_RDIV: if (alu_done) st_q <= B_PT;
				B_PT:   st_q <= B_OUT;
				B_OUT: begin
					tot_q <= '0;
					for (int c = 0; c < 2; c++) begin
						cnt_q[c] <= '0;
						su_q[c]  <= '0;
						sv_q[c]  <= '0;
						suu_q[c] <= '0;
						suv_q[c] <= '0;
					end
					st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: h_q <= head;
			B_PROD: begin
				puu_q <= uu_full[2*FRAC-1:FRAC];
				puv_q <= (h_q.u[FRAC] ^ h_q.v[FRAC]) ?
					-conf_t'({1'b0, uv_full[2*FRAC-1:FRAC]}) :
					conf_t'({1'b0, uv_full[2*FRAC-1:FRAC]});
			end
			B_CUT: begin
				rad_q  <= '0;
				pt_q   <= '0;
				stat_q <= (tot_q < cfg.min_hits || h_q.max_layer < cfg.min_max_layer) ?
					ST_CUT : ST_DEGEN;
			end
			B_M1: if (alu_done) t_q <= pm <<< FRAC;
			B_M2: if (alu_done) d_q <= FIT_W'(dn);
			B_M3: if (alu_done) t_q <= sres_sh;
			B_M4: if (alu_done) nb_q <= diff;
			B_M5: if (alu_done) t_q <= sres;
			B_M6: if (alu_done) na_q <= diff;
			B_D1: if (alu_done) slope_q[cls_q] <= qval;
			B_D2: if (alu_done) off_q[cls_q] <= qval;
			B_AVG: begin
				bavg_q <= avg_b;
				aavg_q <= avg_a;
			end
			B_RDIV: begin
				if (alu_done) begin
					rw_q <= (alu_res > (ALU_W'(1) << 32)) ? {1'b1, 32'd0} : alu_res[32:0];
				end
			end
			B_PT: begin
				rad_q  <= (rw_q > 33'd65535) ? 16'hFFFF : rw_q[15:0];
				pt_q   <= (ptp[48:10] > 39'd65535) ? 16'hFFFF : ptp[25:10];
				stat_q <= ST_OK;
			end
			default: begin
			end
		endcase
	end

endmodule

[verif/conformal_circle_track_fit_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conformal_circle_track_fit_unit_test
// Streams events of wire hits into the fit unit and checks each track result
// against a bit-true fit computed alongside, over several register settings.
// ----------------------------------------------------------------------------
module conformal_circle_track_fit_unit_test;
	import ccf_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int         FIT_WAIT   = 2500;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [4:0]         layer;
		logic [4:0]         max_layer;
		logic               last;
	} hit_t;

	typedef struct {
		logic [15:0]      radius;
		logic [15:0]      pt;
		logic [CNT_W-1:0] even_hits;
		logic [CNT_W-1:0] odd_hits;
		logic [1:0]       status;
	} track_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      cfg_we = 1'b0;
	logic [1:0]                cfg_idx = CFG_MIN_HITS;
	logic [15:0]               cfg_data = '0;
	logic signed [15:0]        hit_x = '0;
	logic signed [15:0]        hit_y = '0;
	logic [4:0]                layer = '0;
	logic [4:0]                max_layer = '0;
	logic                      last_hit = 1'b0;
	logic                      done;
	logic [15:0]               radius;
	logic [15:0]               pt;
	logic [CNT_W-1:0]          even_hits;
	logic [CNT_W-1:0]          odd_hits;
	logic [1:0]                status;

	conformal_circle_track_fit_unit uut (.*);

	hit_t   pending_hits[$];
	track_t track_q[$];
	hit_t   cur;
	int     errors = 0;
	bit     hold = 1'b0;
	int     burst_left = 5;
	int     gap_left = 0;

	// model state
	logic [CNT_W-1:0] m_min_hits = RST_MIN_HITS;
	logic [4:0]       m_min_layer = RST_MIN_MAX_LAYER;
	logic [15:0]      m_pt_scale = RST_PT_SCALE;
	int               cls_cnt[2];
	int               tot_cnt;
	longint           s_u[2], s_v[2], s_uu[2], s_uv[2];

	initial forever #6 clk = ~clk;

	function automatic longint conf_coord(int c, longint unsigned r2);
		logic [63:0] m, q;
		m = (c < 0) ? -c : c;
		q = (m << (6 + FRAC)) / r2;
		if (q > (64'd1 << FRAC) - 1) q = (64'd1 << FRAC) - 1;
		return (c < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint mul_shift(longint a, longint b);
		logic [127:0] p;
		logic [63:0]  ma, mb, m;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = ma * mb;
		m = p[FRAC +: 64];
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint capped_quot(logic signed [191:0] num, logic [191:0] den);
		logic [191:0] m, q;
		m = (num < 0) ? -num : num;
		q = (m << FRAC) / den;
		if (q > VAL_CAP) q = VAL_CAP;
		return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic bit fit_line(int c, output longint slope, output longint offs);
		logic signed [191:0] n, su, sv, suu, suv, d, nb, na;
		slope = 0;
		offs = 0;
		if (cls_cnt[c] < 2) return 0;
		n = cls_cnt[c]; su = s_u[c]; sv = s_v[c]; suu = s_uu[c]; suv = s_uv[c];
		d = ((n * suu) <<< FRAC) - su * su;
		if (d <= 0) return 0;
		nb = ((n * suv) <<< FRAC) - su * sv;
		na = suu * sv - su * suv;
		slope = capped_quot(nb, d);
		offs = capped_quot(na, d);
		return 1;
	endfunction

	function automatic longint half_sum(longint a, longint b);
		longint s;
		s = a / 2 + b / 2 + ((a % 2) + (b % 2)) / 2;
		if (s > longint'(VAL_CAP)) s = VAL_CAP;
		if (s < -longint'(VAL_CAP)) s = -longint'(VAL_CAP);
		return s;
	endfunction

	task automatic track_hit(hit_t h);
		longint unsigned r2;
		longint          u, v;
		int              c;
		track_t          t;
		longint          be, ae, bo, ao, bavg, aavg;
		logic [127:0]    sq, root, cand, r;
		logic [63:0]     rw, p;
		c = h.layer[0];
		r2 = longint'(h.x) * h.x + longint'(h.y) * h.y;
		if (r2 != 0 && tot_cnt < HIT_MAX) begin
			u = conf_coord(h.x, r2);
			v = conf_coord(h.y, r2);
			s_u[c] += u;
			s_v[c] += v;
			s_uu[c] += mul_shift(u, u);
			s_uv[c] += mul_shift(u, v);
			cls_cnt[c]++;
			tot_cnt++;
		end
		if (!h.last) return;
		t.radius = 0;
		t.pt = 0;
		t.status = ST_OK;
		if (tot_cnt < m_min_hits || h.max_layer < m_min_layer) begin
			t.status = ST_CUT;
		end else if (!fit_line(0, be, ae) || !fit_line(1, bo, ao)) begin
			t.status = ST_DEGEN;
		end else begin
			bavg = half_sum(be, bo);
			aavg = half_sum(ae, ao);
			if (aavg == 0) begin
				t.status = ST_DEGEN;
			end else begin
				p = (bavg < 0) ? -bavg : bavg;
				sq = p * p + (128'd1 << (2 * FRAC));
				root = 0;
				for (int i = 63; i >= 0; i--) begin
					cand = root | (128'd1 << i);
					if (cand * cand <= sq) root = cand;
				end
				p = (aavg < 0) ? -aavg : aavg;
				r = (root * 32) / p;
				rw = (r > (128'd1 << 32)) ? (64'd1 << 32) : r[63:0];
				t.radius = (rw > 65535) ? 16'hFFFF : rw[15:0];
				p = (rw * m_pt_scale) >> 10;
				t.pt = (p > 65535) ? 16'hFFFF : p[15:0];
			end
		end
		t.even_hits = CNT_W'(cls_cnt[0]);
		t.odd_hits = CNT_W'(cls_cnt[1]);
		track_q.push_back(t);
		cls_cnt = '{0, 0};
		tot_cnt = 0;
		s_u = '{0, 0}; s_v = '{0, 0}; s_uu = '{0, 0}; s_uv = '{0, 0};
	endtask

	// driver: hits go out in bursts with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) track_hit(cur);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (!hold && pending_hits.size() > 0) begin
					cur = pending_hits.pop_front();
					hit_x <= cur.x;
					hit_y <= cur.y;
					layer <= cur.layer;
					max_layer <= cur.max_layer;
					last_hit <= cur.last;
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (track_q.size() == 0) begin
				$display("%0t: unexpected result radius %0d status %0d", $time, radius, status);
				errors++;
			end else begin
				track_t e;
				e = track_q.pop_front();
				if (radius !== e.radius) begin
					$display("%0t: radius exp %0d got %0d", $time, e.radius, radius);
					errors++;
				end
				if (pt !== e.pt) begin
					$display("%0t: pt exp %0d got %0d", $time, e.pt, pt);
					errors++;
				end
				if (even_hits !== e.even_hits) begin
					$display("%0t: even_hits exp %0d got %0d", $time, e.even_hits, even_hits);
					errors++;
				end
				if (odd_hits !== e.odd_hits) begin
					$display("%0t: odd_hits exp %0d got %0d", $time, e.odd_hits, odd_hits);
					errors++;
				end
				if (status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
					errors++;
				end
			end
		end
	end

	task automatic add_hit(int x, int y, int lay, int maxl, bit last);
		hit_t h;
		h.x = 16'(x); h.y = 16'(y); h.layer = 5'(lay); h.max_layer = 5'(maxl); h.last = last;
		pending_hits.push_back(h);
	endtask

	// hits on a circle through the origin, with some noise hits mixed in
	task automatic add_track(int n, int maxl, int noise_pct);
		real cx, cy, rr, phi, stp, xr, yr;
		int  xi, yi;
		cx = $itor($signed($urandom_range(0, 40000)) - 20000);
		cy = $itor($signed($urandom_range(0, 40000)) - 20000);
		if (cx == 0 && cy == 0) cx = 1000;
		rr = $sqrt(cx * cx + cy * cy);
		phi = $atan2(-cy, -cx);
		stp = ($urandom_range(0, 1) ? 1.0 : -1.0) * (0.02 + $urandom_range(0, 100) / 400.0);
		for (int i = 1; i <= n; i++) begin
			xr = cx + rr * $cos(phi + stp * i);
			yr = cy + rr * $sin(phi + stp * i);
			xi = (xr > 32767) ? 32767 : (xr < -32768) ? -32768 : $rtoi(xr);
			yi = (yr > 32767) ? 32767 : (yr < -32768) ? -32768 : $rtoi(yr);
			if ($urandom_range(1, 100) <= noise_pct) begin
				xi = $signed(16'($urandom));
				yi = $signed(16'($urandom));
			end
			add_hit(xi, yi, (i + $urandom_range(0, 1) * 2) % 32, maxl, i == n);
		end
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_hits.size() > 0 || start || track_q.size() > 0);
		repeat (FIT_WAIT) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= 16'(val);
		case (idx)
			CFG_MIN_HITS:      m_min_hits = CNT_W'(val);
			CFG_MIN_MAX_LAYER: m_min_layer = 5'(val);
			CFG_PT_SCALE:      m_pt_scale = 16'(val);
			default:           ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int items;
		cls_cnt = '{0, 0};
		tot_cnt = 0;
		s_u = '{0, 0}; s_v = '{0, 0}; s_uu = '{0, 0}; s_uv = '{0, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: short event is cut, edge coordinates and origin hits
		add_hit(32767, -32768, 0, 31, 0);
		add_hit(-32768, 32767, 1, 31, 0);
		add_hit(0, 0, 2, 31, 0);
		add_hit(1, 0, 3, 31, 0);
		add_hit(0, -1, 31, 31, 0);
		add_hit(-32768, -32768, 30, 31, 1);
		add_track(32, 31, 0);
		add_track(32, 3, 0);
		drain();

		set_reg(CFG_MIN_HITS, 0);
		set_reg(CFG_MIN_MAX_LAYER, 0);
		set_reg(CFG_UNUSED, 16'hFFFF);
		add_hit(0, 0, 0, 0, 1);
		add_hit(100, 50, 0, 0, 1);
		add_hit(100, 50, 0, 0, 0);
		add_hit(100, 50, 2, 0, 0);
		add_hit(300, 50, 1, 0, 0);
		add_hit(300, 50, 3, 0, 1);
		add_track(8, 0, 0);
		drain();

		items = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin set_reg(CFG_PT_SCALE, 65535); set_reg(CFG_MIN_MAX_LAYER, 31); end
				1: begin set_reg(CFG_PT_SCALE, 0); set_reg(CFG_MIN_MAX_LAYER, 0); end
				2: set_reg(CFG_MIN_HITS, 4096);
				default: begin
					set_reg(CFG_MIN_HITS, $urandom_range(0, 12));
					set_reg(CFG_MIN_MAX_LAYER, $urandom_range(0, 31));
					set_reg(CFG_PT_SCALE, $urandom_range(0, 65535));
				end
			endcase
			while (items < (ph + 1) * 100) begin
				int n;
				n = $urandom_range(2, 20);
				if ($urandom_range(0, 6) == 0) add_track(n, $urandom_range(0, 31), 100);
				else add_track(n, $urandom_range(0, 31), $urandom_range(0, 1) * 10);
				items += n;
			end
			if (ph == 3) begin
				wait (pending_hits.size() == 0);
				hold = 1'b1;
				while (start || track_q.size() > 0) @(posedge clk);
				add_track(10, 31, 0);
				hold = 1'b0;
			end
			drain();
		end

		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#40ms;
		$display("status: fail");
		$finish;
	end

endmodule
